@@ rtl/pird_pkg.sv @@
// shared types, codes and constants of the palette image decoder
package pird_pkg;

  // default sizes, handed down from the top level
  localparam int DEF_PALETTE_ENTRIES = 4096;
  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HEIGHT      = 512;

  // channel widths
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int COLOR_W     = 16;

  // item kinds on in_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLUT_SELECT  = 2'd3;

  // pixel modes
  localparam logic [1:0] MODE_4BPP  = 2'd0;
  localparam logic [1:0] MODE_8BPP  = 2'd1;
  localparam logic [1:0] MODE_16BPP = 2'd2;
  localparam logic [1:0] MODE_24BPP = 2'd3;

  // bytes gathered towards a direct colour
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  // where a pixel's colour comes from
  localparam logic [1:0] SRC_PALETTE = 2'd0;
  localparam logic [1:0] SRC_BGR555  = 2'd1;
  localparam logic [1:0] SRC_RGB888  = 2'd2;

  // pixel request from the issue stage to the output stage
  typedef struct packed {
    logic [1:0]  src;
    logic [23:0] direct;     // bgr555 in low bits, or {b, g, r}
    logic [7:0]  color_index;
    logic        index_valid;
    logic        last_of_run;
    logic        end_of_frame;
  } pix_req_t;

endpackage

@@ rtl/palette_image_to_rgba_decoder.sv @@
// top level: palette image decoder, clut loads and image bytes in, rgba pixels out
// path: a byte waits in the issue stage's holding register, then the pixel and output registers
// throughput: one pixel per cycle unless the output stalls, set by the single palette
//   read port; a 4bpp byte stays held for its high nibble, other items (8/16/24bpp, loads) do not
// reset: synchronous, active low; clears handshakes, counters and control registers,
//   the palette memory keeps its contents and needs no clearing pass
module palette_image_to_rgba_decoder #(
  // palette entries, a power of two
  parameter int PALETTE_ENTRIES = pird_pkg::DEF_PALETTE_ENTRIES,
  parameter int MAX_WIDTH       = pird_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = pird_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes, for the user to make while the decoder is idle; not enforced
  input  logic                             cfg_we,
  input  logic [pird_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pird_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pird_pkg::IN_TDATA_W-1:0]  in_tdata, // palette_addr, palette_word, data_byte, pad
  input  logic [pird_pkg::IN_TUSER_W-1:0]  in_tuser, // cmd
  // pixel items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pird_pkg::OUT_TDATA_W-1:0] out_tdata, // red, green, blue, alpha, color_index
  output logic [pird_pkg::OUT_TUSER_W-1:0] out_tuser, // index_valid, end_of_frame
  output logic                             out_tlast  // last pixel of the byte
);
  import pird_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic          adv, req_valid;
  pix_req_t      req;

  // issue stage: holds one item, runs the frame counters and drives the
  // palette port; loads and reads go in item order, one access a cycle, so a
  // read always sees every earlier load without forwarding
  pird_issue #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT)
  ) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req)
  );

  // palette memory, bgr555 words
  pird_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // colour expansion and the output register
  pird_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req        (req),
    .ram_rdata  (ram_rdata),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/pird_ram.sv @@
// generic single-write, single-read ram with registered read data
module pird_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pird_issue.sv @@
// input holding stage, configuration, frame counters and palette access issue
module pird_issue #(
  parameter int PALETTE_ENTRIES = pird_pkg::DEF_PALETTE_ENTRIES,
  parameter int MAX_WIDTH       = pird_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = pird_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pird_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pird_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pird_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [pird_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                 ram_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]   ram_waddr,
  output logic [pird_pkg::COLOR_W-1:0]         ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]   ram_raddr,
  input  logic                                 adv,
  output logic                                 req_valid,
  output pird_pkg::pix_req_t                   req
);
  import pird_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // held input item
  logic          h_valid_r, h_valid_nxt;
  logic          h_cmd_r;
  logic [11:0]   h_addr_r;
  logic [15:0]   h_word_r;
  logic [7:0]    h_byte_r;
  logic          nib_hi_r, nib_hi_nxt;

  // configuration
  logic [1:0]    mode_r, mode_nxt;
  logic [CW-1:0] wlast_r, wlast_nxt;
  logic [RW-1:0] hlast_r, hlast_nxt;
  logic [7:0]    sel_r, sel_nxt;

  // decode state
  logic [15:0]   held_r, held_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          done_r, done_nxt;

  logic          is_data, emits, fire, consume, row_end, frame_end;
  logic [3:0]    nibble;
  logic [15:0]   pal_addr;

  always_comb begin
    is_data   = (h_cmd_r == CMD_DATA);
    row_end   = (col_r == wlast_r);
    frame_end = row_end && (row_r == hlast_r);
    nibble    = nib_hi_r ? h_byte_r[7:4] : h_byte_r[3:0];

    case (mode_r)
      MODE_4BPP:  emits = 1'b1;
      MODE_8BPP:  emits = 1'b1;
      MODE_16BPP: emits = (phase_r != PH_NONE);
      MODE_24BPP: emits = (phase_r == PH_TWO);
      default:    emits = 1'b0;
    endcase
    emits = emits && is_data && !done_r;

    fire    = h_valid_r && (!emits || adv);
    // a low nibble that does not end a row keeps the byte for its high nibble
    consume = fire && !(emits && (mode_r == MODE_4BPP) && !nib_hi_r && !row_end);

    in_tready = !h_valid_r || consume;

    // palette base is select*16 or select*256, wrapped to the memory size
    if (mode_r == MODE_4BPP) begin
      pal_addr = {4'b0, sel_r, nibble};
    end else begin
      pal_addr = {sel_r, h_byte_r};
    end

    ram_we    = fire && !is_data;
    ram_waddr = AW'({4'b0, h_addr_r});
    ram_wdata = h_word_r;
    ram_re    = fire && emits && (mode_r inside {MODE_4BPP, MODE_8BPP});
    ram_raddr = AW'(pal_addr);

    req_valid          = fire && emits;
    req.color_index    = 8'd0;
    req.index_valid    = 1'b0;
    req.last_of_run    = 1'b1;
    req.end_of_frame   = frame_end;
    req.direct         = {8'd0, h_byte_r, held_r[7:0]};
    case (mode_r)
      MODE_4BPP: begin
        req.src         = SRC_PALETTE;
        req.color_index = {4'b0, nibble};
        req.index_valid = 1'b1;
        req.last_of_run = nib_hi_r || row_end;
      end
      MODE_8BPP: begin
        req.src         = SRC_PALETTE;
        req.color_index = h_byte_r;
        req.index_valid = 1'b1;
      end
      MODE_16BPP: begin
        req.src = SRC_BGR555;
      end
      MODE_24BPP: begin
        req.src    = SRC_RGB888;
        req.direct = {h_byte_r, held_r[15:8], held_r[7:0]};
      end
      default: begin
        req.src = SRC_PALETTE;
      end
    endcase

    // next state
    h_valid_nxt = h_valid_r;
    if (consume) begin
      h_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      h_valid_nxt = 1'b1;
    end

    nib_hi_nxt = nib_hi_r;
    if (consume) begin
      nib_hi_nxt = 1'b0;
    end else if (fire && emits) begin
      nib_hi_nxt = 1'b1;
    end

    held_nxt  = held_r;
    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    done_nxt  = done_r;
    if (fire && is_data && !done_r) begin
      if (mode_r inside {MODE_16BPP, MODE_24BPP}) begin
        if (emits) begin
          held_nxt  = 16'd0;
          phase_nxt = PH_NONE;
        end else if (phase_r == PH_NONE) begin
          held_nxt  = {8'd0, h_byte_r};
          phase_nxt = PH_ONE;
        end else begin
          held_nxt  = {h_byte_r, held_r[7:0]};
          phase_nxt = PH_TWO;
        end
      end
      if (emits) begin
        if (row_end) begin
          col_nxt = '0;
          if (row_r == hlast_r) begin
            row_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end

    mode_nxt  = mode_r;
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    sel_nxt   = sel_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_MODE: mode_nxt = cfg_wdata[1:0];
        REG_IMAGE_WIDTH: begin
          if (cfg_wdata == '0) begin
            wlast_nxt = '0;
          end else if (cfg_wdata > MAX_WIDTH) begin
            wlast_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            wlast_nxt = CW'(cfg_wdata - 11'd1);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_wdata[9:0] == '0) begin
            hlast_nxt = '0;
          end else if (cfg_wdata[9:0] > MAX_HEIGHT) begin
            hlast_nxt = RW'(MAX_HEIGHT - 1);
          end else begin
            hlast_nxt = RW'(cfg_wdata[9:0] - 10'd1);
          end
        end
        REG_CLUT_SELECT: sel_nxt = cfg_wdata[7:0];
        default: sel_nxt = sel_r;
      endcase
      // any register write restarts the frame
      held_nxt  = 16'd0;
      phase_nxt = PH_NONE;
      col_nxt   = '0;
      row_nxt   = '0;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
      nib_hi_r  <= 1'b0;
      mode_r    <= MODE_4BPP;
      wlast_r   <= '0;
      hlast_r   <= '0;
      sel_r     <= 8'd0;
      held_r    <= 16'd0;
      phase_r   <= PH_NONE;
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
    end else begin
      h_valid_r <= h_valid_nxt;
      nib_hi_r  <= nib_hi_nxt;
      mode_r    <= mode_nxt;
      wlast_r   <= wlast_nxt;
      hlast_r   <= hlast_nxt;
      sel_r     <= sel_nxt;
      held_r    <= held_nxt;
      phase_r   <= phase_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      h_cmd_r  <= in_tuser[0];
      h_addr_r <= in_tdata[11:0];
      h_word_r <= in_tdata[27:12];
      h_byte_r <= in_tdata[35:28];
    end
  end

`ifndef SYNTHESIS
  a_one_ram_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("palette write and read in the same cycle");

  a_high_nibble_held: assert property (@(posedge clk) disable iff (!rst_n)
    nib_hi_r |-> (h_valid_r && mode_r == MODE_4BPP))
    else $error("high nibble pending without a held 4bpp byte");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r)
    else $error("column counter past row end");

  a_no_pixel_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req.end_of_frame) |=> !req_valid)
    else $error("pixel issued after end of frame");
`endif

endmodule

@@ rtl/pird_out.sv @@
// pixel stage behind the palette read and the output register
module pird_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  input  pird_pkg::pix_req_t                req,
  input  logic [pird_pkg::COLOR_W-1:0]      ram_rdata,
  output logic                              adv,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pird_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [pird_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                              out_tlast
);
  import pird_pkg::*;

  logic        p_valid_r, p_valid_nxt;
  pix_req_t    p_req_r;
  logic        o_valid_r, o_valid_nxt;
  logic [OUT_TDATA_W-1:0] o_data_r, o_data_nxt;
  logic [OUT_TUSER_W-1:0] o_user_r, o_user_nxt;
  logic        o_last_r, o_last_nxt;
  logic        p_move;
  logic [15:0] c555;
  logic [7:0]  red, green, blue, alpha;

  always_comb begin
    p_move = p_valid_r && (!o_valid_r || out_tready);
    adv    = !p_valid_r || p_move;

    // ram data stays put while this stage waits, since no read is issued
    c555 = (p_req_r.src == SRC_PALETTE) ? ram_rdata : p_req_r.direct[15:0];
    if (p_req_r.src == SRC_RGB888) begin
      red   = p_req_r.direct[7:0];
      green = p_req_r.direct[15:8];
      blue  = p_req_r.direct[23:16];
      alpha = 8'hFF;
    end else begin
      red   = {c555[4:0], 3'b000};
      green = {c555[9:5], 3'b000};
      blue  = {c555[14:10], 3'b000};
      alpha = (c555 == 16'd0) ? 8'h00 : 8'hFF;
    end

    p_valid_nxt = adv ? req_valid : p_valid_r;
    o_valid_nxt = p_move ? 1'b1 : (o_valid_r && !out_tready);
    o_data_nxt  = o_data_r;
    o_user_nxt  = o_user_r;
    o_last_nxt  = o_last_r;
    if (p_move) begin
      o_data_nxt = {p_req_r.color_index, alpha, blue, green, red};
      o_user_nxt = {p_req_r.end_of_frame, p_req_r.index_valid};
      o_last_nxt = p_req_r.last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req_valid) begin
      p_req_r <= req;
    end
    o_data_r <= o_data_nxt;
    o_user_r <= o_user_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_user_r;
  assign out_tlast  = o_last_r;

endmodule
